### rtl/core/slcan_pkg.sv
// Shared types and constants for the serial CAN adapter line parser.
// Used by slcan_line_parse, slcan_frame_line_parser and slcan_chk.
// No dependencies.
package slcan_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned NumBytes       = 8;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_ACK   = 8'h7A;
  localparam logic [7:0] CH_FRAME = 8'h74;

  typedef enum logic [2:0] {
    ST_FRAME      = 3'd0,
    ST_ACK        = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_BAD_HEX    = 3'd5,
    ST_BAD_LEN    = 3'd6,
    ST_BELL       = 3'd7
  } status_e;

  // First member sits in the highest bits: status ends up at bit 0.
  typedef struct packed {
    logic [NumBytes-1:0][7:0] data_byte;
    logic [3:0]               data_length;
    logic [11:0]              frame_id;
    status_e                  status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

### rtl/core/slcan_line_parse.sv
// Line state and end-of-line decision for the serial CAN adapter parser.
// Holds position, line kind, ID, length, payload and first error.
// Depends on slcan_pkg.
module slcan_line_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        char_i,
  output logic              res_valid_o,
  output slcan_pkg::result_t res_o
);
  import slcan_pkg::*;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_PAYLOAD = 2'd2
  } err_e;

  localparam logic [7:0] ChDig0 = 8'h30;
  localparam logic [7:0] ChDig9 = 8'h39;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpF  = 8'h46;
  localparam logic [7:0] ChLoA  = 8'h61;
  localparam logic [7:0] ChLoF  = 8'h66;
  localparam logic [4:0] PosMax = 5'd31;
  localparam logic [4:0] PosLen = 5'd4;
  localparam logic [4:0] PosData = 5'd5;

  logic [4:0]               pos_q, pos_d;
  kind_e                    kind_q, kind_d;
  logic [11:0]              id_q, id_d;
  logic [3:0]               len_q, len_d;
  logic [NumBytes-1:0][7:0] pay_q, pay_d;
  err_e                     err_q, err_d;

  logic       is_end;
  logic       nib_ok;
  logic [3:0] nib;
  logic [4:0] off;
  logic [3:0] idx;
  logic [5:0] need_len;
  logic       len_ok;
  status_e    status;

  assign is_end = (char_i == CH_CR) || (char_i == CH_BELL);

  // hex digit, either case
  always_comb begin
    nib_ok = 1'b1;
    nib    = '0;
    if (char_i >= ChDig0 && char_i <= ChDig9) begin
      nib = 4'(char_i - ChDig0);
    end else if (char_i >= ChUpA && char_i <= ChUpF) begin
      nib = 4'(char_i - ChUpA + 8'd10);
    end else if (char_i >= ChLoA && char_i <= ChLoF) begin
      nib = 4'(char_i - ChLoA + 8'd10);
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign need_len = 6'(PosData) + {1'b0, len_q, 1'b0};
  assign len_ok   = (len_q <= 4'(MAX_DATA_BYTES));
  assign off      = pos_q - PosData;
  assign idx      = off[4:1];

  always_comb begin
    if (pos_q == '0) begin
      status = ST_EMPTY;
    end else if (kind_q == KIND_ACK) begin
      status = ST_ACK;
    end else if (kind_q != KIND_FRAME) begin
      status = ST_BAD_TYPE;
    end else if (pos_q < PosData) begin
      status = ST_INCOMPLETE;
    end else if (err_q == ERR_HEADER) begin
      status = ST_BAD_HEX;
    end else if ({1'b0, pos_q} < need_len) begin
      status = ST_INCOMPLETE;
    end else if (!len_ok) begin
      status = ST_BAD_LEN;
    end else if (err_q == ERR_PAYLOAD) begin
      status = ST_BAD_HEX;
    end else begin
      status = ST_FRAME;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = (char_i == CH_BELL) ? ST_BELL : status;
    if (char_i != CH_BELL && status == ST_FRAME) begin
      res_o.frame_id    = id_q;
      res_o.data_length = len_q;
      for (int i = 0; i < NumBytes; i++) begin
        if (i < MAX_DATA_BYTES && 4'(i) < len_q) begin
          res_o.data_byte[i] = pay_q[i];
        end
      end
    end
  end

  assign res_valid_o = valid_i && is_end;

  always_comb begin
    pos_d  = pos_q;
    kind_d = kind_q;
    id_d   = id_q;
    len_d  = len_q;
    pay_d  = pay_q;
    err_d  = err_q;
    if (valid_i) begin
      if (is_end) begin
        pos_d  = '0;
        kind_d = KIND_NONE;
        id_d   = '0;
        len_d  = '0;
        pay_d  = '0;
        err_d  = ERR_NONE;
      end else begin
        if (pos_q == '0) begin
          kind_d = (char_i == CH_FRAME) ? KIND_FRAME :
                   (char_i == CH_ACK)   ? KIND_ACK : KIND_OTHER;
        end else if (kind_q == KIND_FRAME && pos_q < PosMax) begin
          if (pos_q < PosLen) begin
            if (!nib_ok) begin
              if (err_q == ERR_NONE) err_d = ERR_HEADER;
            end else begin
              id_d = {id_q[7:0], nib};
            end
          end else if (pos_q == PosLen) begin
            if (!nib_ok) begin
              if (err_q == ERR_NONE) err_d = ERR_HEADER;
            end else begin
              len_d = nib;
            end
          end else if (err_q == ERR_NONE && len_ok && {1'b0, pos_q} < need_len &&
                       idx < 4'(NumBytes)) begin
            if (!nib_ok) begin
              err_d = ERR_PAYLOAD;
            end else begin
              pay_d[idx[2:0]] = {pay_q[idx[2:0]][3:0], nib};
            end
          end
        end
        if (pos_q < PosMax) pos_d = pos_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= KIND_NONE;
      id_q   <= '0;
      len_q  <= '0;
      pay_q  <= '0;
      err_q  <= ERR_NONE;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      id_q   <= id_d;
      len_q  <= len_d;
      pay_q  <= pay_d;
      err_q  <= err_d;
    end
  end

endmodule

### rtl/core/slcan_frame_line_parser.sv
// Top level of the serial CAN adapter line parser: input stream, line state,
// and a two-deep result buffer on the output stream.
// Depends on slcan_pkg and slcan_line_parse.

// Takes one ASCII byte per cycle on s_axis and gives one result request on
// m_axis for each CR or BELL byte: a decoded standard frame, an ack, or an
// error status. All other bytes only update the line state. A byte is
// processed in the cycle it is accepted and its result is registered, in the
// skid register if the output register holds a stalled result. The output side
// has an output register plus a skid register; s_axis_tready_o drops only
// while both hold undelivered results, so with a ready sink the block takes
// one byte every cycle indefinitely.
module slcan_frame_line_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] char_in
  input  logic [7:0]                    s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] status, [14:3] frame_id, [18:15] data_length,
  // [26:19] data_byte_0 ... [82:75] data_byte_7, [87:83] zero
  output logic [slcan_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import slcan_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    pop;

  result_t out_q;
  logic    out_valid_q;
  result_t skid_q;
  logic    skid_valid_q;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  slcan_line_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .char_i      (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign pop = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q  <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - ResultW)'(0), out_q};

endmodule

### rtl/core/slcan_chk.sv
// Port-level checks for slcan_frame_line_parser, bound to the top level.
// Depends on slcan_pkg.
// Watches the two stream ports only.
module slcan_assert (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_i,
  input logic [7:0]                    s_axis_tdata_i,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [slcan_pkg::OutDataW-1:0] m_axis_tdata_i
);
  import slcan_pkg::*;

  result_t res;
  logic    acc;

  assign res = m_axis_tdata_i[ResultW-1:0];
  assign acc = s_axis_tvalid_i && s_axis_tready_i;

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // only frames carry id, length and data
  a_nonframe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && res.status != ST_FRAME |->
      res.frame_id == '0 && res.data_length == '0 && res.data_byte == '0)
    else $error("non-frame result with payload");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && res.status == ST_FRAME |-> res.data_length <= 4'(MAX_DATA_BYTES))
    else $error("frame length out of range");

  // ordinary bytes never produce a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !m_axis_tvalid_i && s_axis_tdata_i != CH_CR && s_axis_tdata_i != CH_BELL
      |=> !m_axis_tvalid_i)
    else $error("result without CR or BELL");

  a_bell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !m_axis_tvalid_i && s_axis_tdata_i == CH_BELL
      |=> m_axis_tvalid_i && res.status == ST_BELL)
    else $error("BELL did not give bell status");

endmodule

bind slcan_frame_line_parser slcan_assert u_slcan_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

### sim/slcan_chk.sv
`timescale 1ns / 1ps
// Scoreboard for slcan_frame_line_parser: tracks the line state from the input
// stream, queues one expected result per CR or BELL and checks m_axis requests.
// Depends on slcan_pkg.
module slcan_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // [7:0] char_in
  input  logic [7:0]                     s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // [2:0] status, [14:3] frame_id, [18:15] data_length,
  // [26:19] data_byte_0 ... [82:75] data_byte_7, [87:83] zero
  input  logic [slcan_pkg::OutDataW-1:0] m_tdata_i,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    open_cnt_o
);
  import slcan_pkg::*;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FRAME,
    KIND_ACK,
    KIND_OTHER
  } line_kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_HEADER,
    FAULT_PAYLOAD
  } fault_e;

  localparam logic [4:0] NIB_BAD = 5'd16;
  localparam logic [4:0] POS_SAT = 5'd31;

  logic [4:0]  line_pos;
  line_kind_e  line_type;
  logic [11:0] id_sum;
  logic [3:0]  len_digit;
  logic [7:0]  data_store [NumBytes];
  fault_e      first_fault;

  result_t     frame_q [$];
  result_t     want_r;
  result_t     got_r;
  bit          emits;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    // 'A' and 'a' both have a low nibble of 1
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, c[3:0] + 4'd9};
    return NIB_BAD;
  endfunction

  function automatic status_e line_verdict();
    if (line_pos == 0) return ST_EMPTY;
    if (line_type == KIND_ACK) return ST_ACK;
    if (line_type != KIND_FRAME) return ST_BAD_TYPE;
    if (line_pos < 5) return ST_INCOMPLETE;
    if (first_fault == FAULT_HEADER) return ST_BAD_HEX;
    if (int'(line_pos) < 5 + 2 * int'(len_digit)) return ST_INCOMPLETE;
    if (len_digit > MAX_DATA_BYTES) return ST_BAD_LEN;
    if (first_fault == FAULT_PAYLOAD) return ST_BAD_HEX;
    return ST_FRAME;
  endfunction

  task automatic clear_line();
    line_pos    = '0;
    line_type   = KIND_NONE;
    id_sum      = '0;
    len_digit   = '0;
    first_fault = FAULT_NONE;
    foreach (data_store[i]) data_store[i] = '0;
  endtask

  task automatic parse_char(input logic [7:0] c, output bit has_res, output result_t res);
    logic [4:0]  nib;
    int unsigned idx;
    has_res = 1'b0;
    res     = '0;
    if (c == CH_CR || c == CH_BELL) begin
      has_res    = 1'b1;
      res.status = (c == CH_BELL) ? ST_BELL : line_verdict();
      if (res.status == ST_FRAME) begin
        res.frame_id    = id_sum;
        res.data_length = len_digit;
        for (int i = 0; i < NumBytes; i++) begin
          res.data_byte[i] = (i < len_digit) ? data_store[i] : 8'h00;
        end
      end
      clear_line();
    end else begin
      if (line_pos == 0) begin
        line_type = (c == CH_FRAME) ? KIND_FRAME : (c == CH_ACK) ? KIND_ACK : KIND_OTHER;
      end else if (line_type == KIND_FRAME && line_pos < POS_SAT) begin
        nib = hex_value(c);
        if (line_pos <= 3) begin
          if (nib == NIB_BAD) begin
            if (first_fault == FAULT_NONE) first_fault = FAULT_HEADER;
          end else begin
            id_sum = {id_sum[7:0], nib[3:0]};
          end
        end else if (line_pos == 4) begin
          if (nib == NIB_BAD) begin
            if (first_fault == FAULT_NONE) first_fault = FAULT_HEADER;
          end else begin
            len_digit = nib[3:0];
          end
        end else if (first_fault == FAULT_NONE && len_digit <= MAX_DATA_BYTES &&
                     int'(line_pos) < 5 + 2 * int'(len_digit)) begin
          // only the digits the length calls for; anything after is ignored
          idx = (int'(line_pos) - 5) >> 1;
          if (nib == NIB_BAD) begin
            first_fault = FAULT_PAYLOAD;
          end else begin
            data_store[idx] = {data_store[idx][3:0], nib[3:0]};
          end
        end
      end
      if (line_pos < POS_SAT) line_pos = line_pos + 5'd1;
    end
  endtask

  task automatic note_mismatch(input string field, input int unsigned want_v,
                               input int unsigned got_v);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) begin
      $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      frame_q.delete();
      fail_cnt_o = 0;
      open_cnt_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        parse_char(s_tdata_i, emits, want_r);
        if (emits) frame_q = {frame_q, want_r};
      end
      if (m_tvalid_i && m_tready_i) begin
        got_r = m_tdata_i[ResultW-1:0];
        if (frame_q.size() == 0) begin
          note_mismatch("unexpected result request, status", 0, got_r.status);
        end else begin
          want_r = frame_q.pop_front();
          if (got_r.status != want_r.status)
            note_mismatch("status", want_r.status, got_r.status);
          if (got_r.frame_id != want_r.frame_id)
            note_mismatch("frame_id", want_r.frame_id, got_r.frame_id);
          if (got_r.data_length != want_r.data_length)
            note_mismatch("data_length", want_r.data_length, got_r.data_length);
          for (int i = 0; i < NumBytes; i++) begin
            if (got_r.data_byte[i] != want_r.data_byte[i])
              note_mismatch($sformatf("data_byte_%0d", i), want_r.data_byte[i],
                            got_r.data_byte[i]);
          end
          if (m_tdata_i[OutDataW-1:ResultW] != '0)
            note_mismatch("padding", 0, m_tdata_i[OutDataW-1:ResultW]);
        end
      end
      open_cnt_o = frame_q.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Top of the line parser bench: clock, reset, byte stimulus with random gaps
// and a stalling sink; verdict from the slcan_chk scoreboard.
// Depends on slcan_pkg, slcan_frame_line_parser and slcan_chk.
module testbench;
  import slcan_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1650;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [7:0]          s_tdata  = 8'h00;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned fail_cnt;
  int unsigned open_cnt;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned base_cnt;
  int unsigned rx_stall;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  logic [7:0]  line_q [$];

  always #10 clk = ~clk;

  slcan_frame_line_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  slcan_chk chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .fail_cnt_o (fail_cnt),
    .open_cnt_o (open_cnt)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // biased toward 0 and F so ids and data hit their extremes
  function automatic logic [3:0] rand_nibble();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'h0;
    if (r == 1) return 4'hF;
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + n;
    return 8'((($urandom_range(0, 1) == 1) ? "a" : "A") + n - 10);
  endfunction

  function automatic logic [7:0] plain_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_BELL);
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = plain_noise();
    while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
    return b;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    line_q = {line_q, b};
  endtask

  task automatic push_body(input int unsigned len_n);
    queue_byte(CH_FRAME);
    repeat (3) queue_byte(hex_char(rand_nibble()));
    queue_byte(hex_char(4'(len_n)));
    repeat (2 * len_n) queue_byte(hex_char(rand_nibble()));
  endtask

  task automatic cut_line();
    int unsigned cut;
    cut = $urandom_range(1, line_q.size() - 1);
    while (line_q.size() > cut) void'(line_q.pop_back());
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap_n;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
    gap_n = pick_gap();
    if (gap_n != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_n) @(posedge clk);
    end
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(term);
  endtask

  task automatic run_random_line();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (pick < 50) begin
      push_body(($urandom_range(0, 6) == 0) ? 8 : $urandom_range(0, 8));
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) queue_byte(plain_noise());
      queue_byte(CH_CR);
    end else if (pick < 58) begin
      push_body($urandom_range(0, 8));
      cut_line();
      queue_byte(CH_CR);
    end else if (pick < 66) begin
      push_body($urandom_range(1, 8));
      k = $urandom_range(1, line_q.size() - 1);
      line_q[k] = non_hex();
      queue_byte(CH_CR);
    end else if (pick < 71) begin
      // length digit above the limit; long ones run into saturation
      push_body($urandom_range(9, 15));
      if ($urandom_range(0, 1) == 1) cut_line();
      queue_byte(CH_CR);
    end else if (pick < 76) begin
      queue_byte(CH_ACK);
      repeat ($urandom_range(0, 3)) queue_byte(plain_noise());
      queue_byte(CH_CR);
    end else if (pick < 80) begin
      queue_byte(CH_CR);
    end else if (pick < 85) begin
      do k = $urandom_range(0, 255);
      while (k == CH_FRAME || k == CH_ACK || k == CH_CR || k == CH_BELL);
      queue_byte(8'(k));
      repeat ($urandom_range(0, 6)) queue_byte(plain_noise());
      queue_byte(CH_CR);
    end else if (pick < 89) begin
      push_body($urandom_range(0, 8));
      cut_line();
      queue_byte(CH_BELL);
    end else if (pick < 94) begin
      push_body($urandom_range(0, 8));
      repeat ($urandom_range(20, 30)) queue_byte(plain_noise());
      queue_byte(CH_CR);
    end else begin
      repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
      queue_byte(CH_CR);
    end
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // sink side: random ready pattern plus one long hold-off
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        rx_stall = pick_gap();
        if (rx_stall != 0) begin
          m_tready <= 1'b0;
          repeat (rx_stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(CH_CR);                                    // empty line
    send_line("z", CH_CR);                               // ack
    send_byte(8'hFF);                                    // bad type
    send_byte(CH_CR);
    send_byte(CH_FRAME);                                 // short header
    send_byte("1");
    send_byte(8'h00);
    send_byte(CH_CR);
    send_line("t1G30", CH_CR);                           // bad id digit
    send_line("t0001a", CH_CR);                          // short payload
    send_line("t7fF1aB", CH_CR);                         // mixed case frame
    send_line("t0001zz", CH_CR);                         // bad data digit
    send_line("t123", CH_BELL);                          // bell drops the line

    hold_req = 1'b1;
    base_cnt = sent_cnt;
    while (sent_cnt - base_cnt < RANDOM_BYTES) run_random_line();
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    wait (open_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### slcan_frame_line_parser.f
rtl/core/slcan_pkg.sv
rtl/core/slcan_line_parse.sv
rtl/core/slcan_frame_line_parser.sv
rtl/core/slcan_chk.sv
sim/slcan_chk.sv
sim/testbench.sv
